### rtl/cad_pkg.sv
// Shared types and constants for the circular array deque.
`default_nettype none
package cad_pkg;

  localparam int CAPACITY = 64;
  localparam int AW       = $clog2(CAPACITY);
  localparam int CW       = $clog2(CAPACITY + 1);
  localparam int POS_W    = 7;
  localparam int DATA_W   = 32;

  typedef enum logic [1:0] {
    ACT_GET    = 2'd0,
    ACT_SET    = 2'd1,
    ACT_INSERT = 2'd2,
    ACT_REMOVE = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

endpackage
`default_nettype wire

### rtl/cad_in_if.sv
// Request channel: action, logical position and write data.
`default_nettype none
interface cad_in_if;
  import cad_pkg::*;

  logic                     valid;
  logic                     ready;
  action_t                  action;
  logic [POS_W-1:0]         position;
  logic signed [DATA_W-1:0] data_in;

  modport source(output valid, action, position, data_in, input ready);
  modport sink(input valid, action, position, data_in, output ready);
endinterface
`default_nettype wire

### rtl/cad_out_if.sv
// Result channel: returned element, status and occupancy.
`default_nettype none
interface cad_out_if;
  import cad_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] data_out;
  status_t                  status;
  logic [POS_W-1:0]         occupancy;

  modport source(output valid, data_out, status, occupancy, input ready);
  modport sink(input valid, data_out, status, occupancy, output ready);
endinterface
`default_nettype wire

### rtl/circular_array_deque.sv
// Fixed-capacity deque in a circular single-port-write, single-port-read store.
// Sequence: accept, check, then a read wait for get, set and remove; insert and remove then
//   shift n elements (at most about count/2) and finalise; rejected requests go from the
//   check straight to the result.
// Throughput: one transaction at a time; the shift loop moves one element per cycle,
//   pipelined read-then-write. A stalled result holds the block in S_DONE.
// Reset: synchronous active-low rst_n empties the deque (head and count to zero);
//   store contents are not cleared and no clearing pass is run.
`default_nettype none
module circular_array_deque (
  input  wire        clk,
  input  wire        rst_n,
  cad_in_if.sink     in_if,
  cad_out_if.source  out_if
);
  import cad_pkg::*;

  localparam int SW = CW + 1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_RDWAIT,
    S_MOVE,
    S_FINAL,
    S_DONE
  } state_t;

  state_t            state_r;
  logic [AW-1:0]     head_r;
  logic [CW-1:0]     count_r;

  action_t           act_r;
  logic [CW-1:0]     pos_r;
  logic [DATA_W-1:0] data_r;

  // shift sequencer
  logic [AW-1:0]     ptr_r;
  logic [AW-1:0]     tgt_r;
  logic [AW-1:0]     wa_r;
  logic [AW-1:0]     fin_r;
  logic [AW-1:0]     new_head_r;
  logic [CW-1:0]     moves_r;
  logic              up_r;
  logic              pend_r;

  logic [DATA_W-1:0] res_data_r;
  status_t           res_st_r;

  logic              out_valid_r;
  logic [DATA_W-1:0] out_data_r;
  status_t           out_st_r;
  logic [CW-1:0]     out_occ_r;

  // store
  logic [DATA_W-1:0] mem [CAPACITY];
  logic [DATA_W-1:0] mem_q_r;
  logic              mem_we;
  logic              mem_re;
  logic [AW-1:0]     mem_wa;
  logic [AW-1:0]     mem_ra;
  logic [DATA_W-1:0] mem_wd;

  logic [AW-1:0]     slot_pos;
  logic [AW-1:0]     slot_cnt;
  logic              front;

  function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] a, input logic [CW-1:0] b);
    logic [SW-1:0] s;
    s = SW'(a) + SW'(b);
    if (s >= SW'(CAPACITY)) s = s - SW'(CAPACITY);
    return s[AW-1:0];
  endfunction

  function automatic logic [AW-1:0] step(input logic [AW-1:0] a, input logic up);
    logic [AW-1:0] r;
    if (up) r = (a == AW'(CAPACITY - 1)) ? '0 : a + AW'(1);
    else    r = (a == '0) ? AW'(CAPACITY - 1) : a - AW'(1);
    return r;
  endfunction

  assign slot_pos = wrap_add(head_r, pos_r);
  assign slot_cnt = wrap_add(head_r, count_r);
  assign front    = pos_r < (count_r >> 1);

  assign in_if.ready      = (state_r == S_IDLE);
  assign out_if.valid     = out_valid_r;
  assign out_if.data_out  = $signed(out_data_r);
  assign out_if.status    = out_st_r;
  assign out_if.occupancy = POS_W'(out_occ_r);

  always_comb begin
    mem_re = 1'b0;
    mem_ra = slot_pos;
    mem_we = 1'b0;
    mem_wa = wa_r;
    mem_wd = mem_q_r;
    unique case (state_r)
      S_CHECK: begin
        if (act_r != ACT_INSERT && pos_r < count_r) mem_re = 1'b1;
      end
      S_RDWAIT: begin
        if (act_r == ACT_SET) begin
          mem_we = 1'b1;
          mem_wa = slot_pos;
          mem_wd = data_r;
        end
      end
      S_MOVE: begin
        if (moves_r != '0) begin
          mem_re = 1'b1;
          mem_ra = ptr_r;
        end
        mem_we = pend_r;
      end
      S_FINAL: begin
        if (act_r == ACT_INSERT) begin
          mem_we = 1'b1;
          mem_wa = fin_r;
          mem_wd = data_r;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    if (mem_re) mem_q_r <= mem[mem_ra];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
      pend_r      <= 1'b0;
    end else begin
      // S_DONE reloads the output register itself
      if (out_valid_r && out_if.ready && state_r != S_DONE) out_valid_r <= 1'b0;

      unique case (state_r)
        S_IDLE: begin
          if (in_if.valid) begin
            act_r   <= in_if.action;
            pos_r   <= CW'(in_if.position);
            data_r  <= $unsigned(in_if.data_in);
            state_r <= S_CHECK;
          end
        end

        S_CHECK: begin
          res_data_r <= '0;
          res_st_r   <= ST_OK;
          pend_r     <= 1'b0;
          unique case (act_r) inside
            ACT_INSERT: begin
              if (pos_r > count_r) begin
                res_st_r <= ST_RANGE;
                state_r  <= S_DONE;
              end else if (count_r == CW'(CAPACITY)) begin
                res_st_r <= ST_FULL;
                state_r  <= S_DONE;
              end else begin
                if (front) begin
                  // head moves back one; slide front elements toward it
                  new_head_r <= step(head_r, 1'b0);
                  tgt_r      <= step(head_r, 1'b0);
                  ptr_r      <= head_r;
                  up_r       <= 1'b1;
                  moves_r    <= pos_r;
                  fin_r      <= step(slot_pos, 1'b0);
                end else begin
                  new_head_r <= head_r;
                  tgt_r      <= slot_cnt;
                  ptr_r      <= step(slot_cnt, 1'b0);
                  up_r       <= 1'b0;
                  moves_r    <= count_r - pos_r;
                  fin_r      <= slot_pos;
                end
                state_r <= S_MOVE;
              end
            end
            ACT_GET, ACT_SET, ACT_REMOVE: begin
              if (pos_r >= count_r) begin
                res_st_r <= ST_RANGE;
                state_r  <= S_DONE;
              end else begin
                state_r <= S_RDWAIT;
              end
            end
            default: state_r <= S_DONE;
          endcase
        end

        S_RDWAIT: begin
          res_data_r <= mem_q_r;
          res_st_r   <= ST_OK;
          if (act_r == ACT_REMOVE) begin
            tgt_r  <= slot_pos;
            pend_r <= 1'b0;
            if (front) begin
              ptr_r      <= step(slot_pos, 1'b0);
              up_r       <= 1'b0;
              moves_r    <= pos_r;
              new_head_r <= step(head_r, 1'b1);
            end else begin
              ptr_r      <= step(slot_pos, 1'b1);
              up_r       <= 1'b1;
              moves_r    <= count_r - CW'(1) - pos_r;
              new_head_r <= head_r;
            end
            state_r <= S_MOVE;
          end else begin
            state_r <= S_DONE;
          end
        end

        S_MOVE: begin
          // read at ptr, write last cycle's data one slot behind
          if (moves_r != '0) begin
            wa_r    <= tgt_r;
            tgt_r   <= ptr_r;
            ptr_r   <= step(ptr_r, up_r);
            moves_r <= moves_r - CW'(1);
            pend_r  <= 1'b1;
          end else begin
            pend_r <= 1'b0;
            if (!pend_r) state_r <= S_FINAL;
          end
        end

        S_FINAL: begin
          head_r  <= new_head_r;
          count_r <= (act_r == ACT_INSERT) ? count_r + CW'(1) : count_r - CW'(1);
          state_r <= S_DONE;
        end

        S_DONE: begin
          if (!out_valid_r || out_if.ready) begin
            out_valid_r <= 1'b1;
            out_data_r  <= res_data_r;
            out_st_r    <= res_st_r;
            out_occ_r   <= count_r;
            state_r     <= S_IDLE;
          end
        end

        default: state_r <= S_IDLE;
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(CAPACITY))
    else $error("element count above capacity");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_if.valid && in_if.ready) |=> !in_if.ready)
    else $error("ready while a transaction is in progress");

  a_move_no_collide: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MOVE && mem_we && mem_re) |-> (mem_wa != mem_ra))
    else $error("shift read and write hit the same slot");

  a_error_zero_data: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_st_r != ST_OK) |-> (out_data_r == '0))
    else $error("error result carries nonzero data");

  a_full_occ: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_st_r == ST_FULL) |-> (out_occ_r == CW'(CAPACITY)))
    else $error("full status with store not full");
`endif

endmodule
`default_nettype wire
